### rtl/core/integer_pixel_replicating_upscaler_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer pixel replicating upscaler
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PIXEL_REPLICATING_UPSCALER_TOP_DEFINES_SVH
`define INTEGER_PIXEL_REPLICATING_UPSCALER_TOP_DEFINES_SVH

// Same-cycle implication.
`define IPRU_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define IPRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/ipru_pkg.sv
// ----------------------------------------------------------------------------
// ipru_pkg
// Constants and types for the integer pixel replicating upscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipru_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 12;
    localparam int FACTOR_W   = 7;
    localparam int HEIGHT_W   = 16;
    localparam int PIXEL_W    = 24;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [FACTOR_W-1:0] FACTOR_MAX = FACTOR_W'(100);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);

    typedef enum logic [1:0] {
        ST_LOADED   = 2'd0,
        ST_PIXEL    = 2'd1,
        ST_PAD      = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_FACTOR  = 2'd0,
        CFG_SOURCE_WIDTH  = 2'd1,
        CFG_SOURCE_HEIGHT = 2'd2
    } cfg_idx_t;

endpackage

### rtl/core/integer_pixel_replicating_upscaler_top.sv
// ----------------------------------------------------------------------------
// integer_pixel_replicating_upscaler_top
// Nearest-neighbour integer upscaler for 24-bit BMP rows: loads one source
// row into a line buffer, then emits each pixel factor times with row padding,
// the whole padded row factor times.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                               | tuser       | tlast
//  ---------+-----+-------------------------------------+-------------+--------
//  s_*      | in  | blue[7:0] green[15:8] red[23:16]    | func        | -
//  m_*      | out | blue, green, red, image_end[24]     | status[1:0] | row_end
//  cfg_*    | in  | cfg_data: register value, cfg_index selects register
//
//  One transfer per clock in each direction while m_tready is high; each result
//  passes the line buffer read port (registered read) in the first stage, then
//  the output register. The input side stalls only when both stages hold
//  results and m_tready is low. Reset is asynchronous and clears control state;
//  the line buffer contents are undefined until loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_pixel_replicating_upscaler_top_defines.svh"

module integer_pixel_replicating_upscaler_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    // slave stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,   // in_blue, in_green, in_red
    input  logic                              s_tuser,   // func
    // master stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // out_blue, out_green, out_red,
                                                         // image_end, zero fill
    output logic [1:0]                        m_tuser,   // status
    output logic                              m_tlast,   // row_end
    // configuration
    input  logic                              cfg_we,
    input  logic [ipru_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ipru_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ipru_pkg::FACTOR_W-1:0] scale_factor_reg;
    logic [ipru_pkg::WIDTH_W-1:0]  source_width_reg;
    logic [ipru_pkg::HEIGHT_W-1:0] source_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_factor_reg  <= ipru_pkg::FACTOR_W'(1);
            source_width_reg  <= ipru_pkg::WIDTH_W'(1);
            source_height_reg <= ipru_pkg::HEIGHT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ipru_pkg::CFG_SCALE_FACTOR:
                    scale_factor_reg  <= cfg_data[ipru_pkg::FACTOR_W-1:0];
                ipru_pkg::CFG_SOURCE_WIDTH:
                    source_width_reg  <= cfg_data[ipru_pkg::WIDTH_W-1:0];
                ipru_pkg::CFG_SOURCE_HEIGHT:
                    source_height_reg <= cfg_data[ipru_pkg::HEIGHT_W-1:0];
                default:
                    ;   // unmapped index: ignored
            endcase
        end
    end

    // Clamped limits
    logic [ipru_pkg::FACTOR_W-1:0] eff_factor;
    logic [ipru_pkg::WIDTH_W-1:0]  eff_width;
    logic [ipru_pkg::HEIGHT_W-1:0] eff_height;
    logic [1:0]                    wf_low;
    logic [1:0]                    bytes_low;
    logic [1:0]                    pad_count;

    always_comb
    begin
        if (scale_factor_reg == '0)
            eff_factor = ipru_pkg::FACTOR_W'(1);
        else if (scale_factor_reg > ipru_pkg::FACTOR_MAX)
            eff_factor = ipru_pkg::FACTOR_MAX;
        else
            eff_factor = scale_factor_reg;

        if (source_width_reg == '0)
            eff_width = ipru_pkg::WIDTH_W'(1);
        else if (source_width_reg > ipru_pkg::WIDTH_MAX)
            eff_width = ipru_pkg::WIDTH_MAX;
        else
            eff_width = source_width_reg;

        eff_height = (source_height_reg == '0) ? ipru_pkg::HEIGHT_W'(1)
                                                : source_height_reg;

        // Pad bytes depend only on (width * factor * 3) mod 4.
        wf_low    = 2'(eff_width[1:0] * eff_factor[1:0]);
        bytes_low = 2'(wf_low + {wf_low[0], 1'b0});
        pad_count = 2'(2'd0 - bytes_low);
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline advance
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic out_advance;
    logic in_accept;

    assign out_advance = !m_valid_reg || m_tready;
    assign s_tready    = !s1_valid_reg || out_advance;
    assign in_accept   = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Sequencing state
    // ------------------------------------------------------------------
    logic                          emit_phase_reg,   emit_phase_next;
    logic [ipru_pkg::ADDR_W-1:0]   load_index_reg,   load_index_next;
    logic [ipru_pkg::ADDR_W-1:0]   out_column_reg,   out_column_next;
    logic [ipru_pkg::FACTOR_W-1:0] pixel_repeat_reg, pixel_repeat_next;
    logic [ipru_pkg::FACTOR_W-1:0] row_repeat_reg,   row_repeat_next;
    logic [1:0]                    pad_index_reg,    pad_index_next;
    logic [ipru_pkg::HEIGHT_W-1:0] rows_done_reg,    rows_done_next;
    logic                          padding_reg,      padding_next;

    // Result of the item being accepted
    ipru_pkg::status_t status_new;
    logic              row_end_new;
    logic              image_end_new;
    logic              mem_write;
    logic              mem_read;

    // Incremented counters, one bit wider for the compare
    logic [ipru_pkg::WIDTH_W-1:0]   load_inc;
    logic [ipru_pkg::WIDTH_W-1:0]   column_inc;
    logic [ipru_pkg::FACTOR_W:0]    pixel_inc;
    logic [ipru_pkg::FACTOR_W:0]    row_inc;
    logic [2:0]                     pad_inc;
    logic [ipru_pkg::HEIGHT_W:0]    rows_inc;
    logic                           row_finished;

    assign load_inc   = ipru_pkg::WIDTH_W'(load_index_reg) + ipru_pkg::WIDTH_W'(1);
    assign column_inc = ipru_pkg::WIDTH_W'(out_column_reg) + ipru_pkg::WIDTH_W'(1);
    assign pixel_inc  = {1'b0, pixel_repeat_reg} + (ipru_pkg::FACTOR_W+1)'(1);
    assign row_inc    = {1'b0, row_repeat_reg} + (ipru_pkg::FACTOR_W+1)'(1);
    assign pad_inc    = {1'b0, pad_index_reg} + 3'd1;
    assign rows_inc   = {1'b0, rows_done_reg} + (ipru_pkg::HEIGHT_W+1)'(1);

    always_comb
    begin
        emit_phase_next   = emit_phase_reg;
        load_index_next   = load_index_reg;
        out_column_next   = out_column_reg;
        pixel_repeat_next = pixel_repeat_reg;
        row_repeat_next   = row_repeat_reg;
        pad_index_next    = pad_index_reg;
        rows_done_next    = rows_done_reg;
        padding_next      = padding_reg;
        status_new        = ipru_pkg::ST_REJECTED;
        row_end_new       = 1'b0;
        image_end_new     = 1'b0;
        mem_write         = 1'b0;
        mem_read          = 1'b0;
        row_finished      = 1'b0;

        if (s_tuser != emit_phase_reg)
        begin
            status_new = ipru_pkg::ST_REJECTED;   // wrong phase, no state change
        end
        else if (!s_tuser)
        begin
            // load one source pixel
            status_new = ipru_pkg::ST_LOADED;
            mem_write  = 1'b1;
            if (load_inc >= eff_width)
            begin
                load_index_next = '0;
                emit_phase_next = 1'b1;
            end
            else
            begin
                load_index_next = load_inc[ipru_pkg::ADDR_W-1:0];
            end
        end
        else if (padding_reg)
        begin
            status_new = ipru_pkg::ST_PAD;
            if (pad_inc >= {1'b0, pad_count})
            begin
                pad_index_next = '0;
                padding_next   = 1'b0;
                row_end_new    = 1'b1;
                row_finished   = 1'b1;
            end
            else
            begin
                pad_index_next = pad_inc[1:0];
            end
        end
        else
        begin
            status_new = ipru_pkg::ST_PIXEL;
            mem_read   = 1'b1;
            if (pixel_inc >= {1'b0, eff_factor})
            begin
                pixel_repeat_next = '0;
                if (column_inc >= eff_width)
                begin
                    out_column_next = '0;
                    if (pad_count != 2'd0)
                    begin
                        padding_next = 1'b1;
                    end
                    else
                    begin
                        row_end_new  = 1'b1;
                        row_finished = 1'b1;
                    end
                end
                else
                begin
                    out_column_next = column_inc[ipru_pkg::ADDR_W-1:0];
                end
            end
            else
            begin
                pixel_repeat_next = pixel_inc[ipru_pkg::FACTOR_W-1:0];
            end
        end

        // end of one output row: count row repeats, then source rows
        if (row_finished)
        begin
            if (row_inc >= {1'b0, eff_factor})
            begin
                row_repeat_next = '0;
                emit_phase_next = 1'b0;
                if (rows_inc >= {1'b0, eff_height})
                begin
                    rows_done_next = '0;
                    image_end_new  = 1'b1;
                end
                else
                begin
                    rows_done_next = rows_inc[ipru_pkg::HEIGHT_W-1:0];
                end
            end
            else
            begin
                row_repeat_next = row_inc[ipru_pkg::FACTOR_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Line buffer: one write or one registered read per transfer
    // ------------------------------------------------------------------
    logic [ipru_pkg::PIXEL_W-1:0] row_store [ipru_pkg::MAX_WIDTH];
    logic [ipru_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept && mem_write)
            row_store[load_index_reg] <= s_tdata[ipru_pkg::PIXEL_W-1:0];
        if (in_accept && mem_read)
            rd_data_reg <= row_store[out_column_reg];
    end

    // ------------------------------------------------------------------
    // Stage 1 (control beside the RAM read) and output register
    // ------------------------------------------------------------------
    ipru_pkg::status_t             s1_status_reg;
    logic                          s1_row_end_reg;
    logic                          s1_image_end_reg;
    ipru_pkg::status_t             out_status_reg;
    logic [ipru_pkg::PIXEL_W-1:0]  out_pixel_reg;
    logic                          out_row_end_reg;
    logic                          out_image_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_phase_reg   <= 1'b0;
            load_index_reg   <= '0;
            out_column_reg   <= '0;
            pixel_repeat_reg <= '0;
            row_repeat_reg   <= '0;
            pad_index_reg    <= '0;
            rows_done_reg    <= '0;
            padding_reg      <= 1'b0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                emit_phase_reg   <= emit_phase_next;
                load_index_reg   <= load_index_next;
                out_column_reg   <= out_column_next;
                pixel_repeat_reg <= pixel_repeat_next;
                row_repeat_reg   <= row_repeat_next;
                pad_index_reg    <= pad_index_next;
                rows_done_reg    <= rows_done_next;
                padding_reg      <= padding_next;
            end
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (out_advance)
                m_valid_reg <= s1_valid_reg;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_status_reg    <= status_new;
            s1_row_end_reg   <= row_end_new;
            s1_image_end_reg <= image_end_new;
        end
        if (out_advance && s1_valid_reg)
        begin
            out_status_reg    <= s1_status_reg;
            out_pixel_reg     <= (s1_status_reg == ipru_pkg::ST_PIXEL) ? rd_data_reg : '0;
            out_row_end_reg   <= s1_row_end_reg;
            out_image_end_reg <= s1_image_end_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_row_end_reg;
    assign m_tdata  = {7'd0, out_image_end_reg, out_pixel_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IPRU_ASSERT_IMPLY(a_image_end_on_row_end, clk, rst_n,
        m_tvalid && m_tdata[24], m_tlast)
    `IPRU_ASSERT_IMPLY(a_pixel_zero_unless_pixel, clk, rst_n,
        m_tvalid && (m_tuser != ipru_pkg::ST_PIXEL), m_tdata[23:0] == 24'd0)
    `IPRU_ASSERT_NEXT(a_reject_keeps_phase, clk, rst_n,
        in_accept && (s_tuser != emit_phase_reg), $stable(emit_phase_reg))
    `IPRU_ASSERT_IMPLY(a_pad_count_only_padding, clk, rst_n,
        pad_index_reg != 2'd0, padding_reg && emit_phase_reg)

endmodule

### dv/integer_pixel_replicating_upscaler_top_test.sv
// ----------------------------------------------------------------------------
// integer_pixel_replicating_upscaler_top_test
// Self-checking bench for the pixel replicating upscaler. A behavioural
// predictor tracks line buffer, counters and registers; every input transfer
// queues the result it must cause and each output transfer is compared
// field by field against the oldest queued result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_pixel_replicating_upscaler_top_test;

    // func codes carried in s_tuser
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EMIT = 1'b1;

    localparam int PIPE_DEPTH   = 2;     // registers from input transfer to result, per RTL header
    localparam int TAIL_CYCLES  = PIPE_DEPTH + 6;
    localparam int HOLD_CYCLES  = 150;   // long receiver hold-off
    localparam int STALL_LIMIT  = 2000;  // cycles with no transfer before giving up

    // one output transfer as the predictor sees it
    typedef struct packed {
        ipru_pkg::status_t status;
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic              row_end;
        logic              image_end;
    } upscale_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [23:0]                     s_tdata;   // in_blue, in_green, in_red
    logic                            s_tuser;   // func
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;   // out_blue, out_green, out_red, image_end,
                                                // zero fill
    logic [1:0]                      m_tuser;   // status
    logic                            m_tlast;   // row_end
    logic                            cfg_we;
    ipru_pkg::cfg_idx_t              cfg_index;
    logic [ipru_pkg::CFG_DATA_W-1:0] cfg_data;

    integer_pixel_replicating_upscaler_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor state: mirror of the registers, the line buffer and counters
    // ------------------------------------------------------------------------
    logic [ipru_pkg::FACTOR_W-1:0] factor_reg = ipru_pkg::FACTOR_W'(1);
    logic [ipru_pkg::WIDTH_W-1:0]  width_reg  = ipru_pkg::WIDTH_W'(1);
    logic [ipru_pkg::HEIGHT_W-1:0] height_reg = ipru_pkg::HEIGHT_W'(1);

    logic [ipru_pkg::PIXEL_W-1:0]  line_buf [ipru_pkg::MAX_WIDTH];
    bit                  in_emit     = 1'b0;
    bit                  in_pad      = 1'b0;
    int unsigned         load_pos    = 0;
    int unsigned         col_pos     = 0;
    int unsigned         px_rep      = 0;
    int unsigned         row_rep     = 0;
    int unsigned         pad_pos     = 0;
    int unsigned         rows_out    = 0;

    upscale_result_t     expected_results [$];

    // bench control and tallies
    bit                  idle_on        = 1'b1;
    bit                  last_row_end   = 1'b0;
    int unsigned         holds_asked    = 0;
    int unsigned         n_errors       = 0;
    int unsigned         n_useful_sent  = 0;
    int unsigned         n_settings     = 0;
    int unsigned         n_loaded       = 0;
    int unsigned         n_pixels       = 0;
    int unsigned         n_pads         = 0;
    int unsigned         n_rejects      = 0;
    int unsigned         n_images       = 0;

    function automatic int unsigned eff_factor();
        if (factor_reg == 0)
            return 1;
        if (factor_reg > ipru_pkg::FACTOR_MAX)
            return ipru_pkg::FACTOR_MAX;
        return factor_reg;
    endfunction

    function automatic int unsigned eff_width();
        if (width_reg == 0)
            return 1;
        if (width_reg > ipru_pkg::MAX_WIDTH)
            return ipru_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    // end of one output row; returns the image_end flag
    function automatic logic close_output_row();
        int unsigned h;
        h = (height_reg == 0) ? 1 : height_reg;
        row_rep++;
        if (row_rep >= eff_factor())
        begin
            row_rep = 0;
            in_emit = 1'b0;
            rows_out++;
            if (rows_out >= h)
            begin
                rows_out = 0;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // advance the predictor by one accepted input transfer
    function automatic upscale_result_t predict_upscale(input logic func,
                                                        input logic [23:0] pixel);
        upscale_result_t res;
        int unsigned     w;
        int unsigned     f;
        int unsigned     pad;
        logic [23:0]     px;
        res = '0;
        res.status = ipru_pkg::ST_REJECTED;
        w = eff_width();
        f = eff_factor();
        if (func == FUNC_LOAD)
        begin
            if (in_emit)
                return res;
            if (load_pos < ipru_pkg::MAX_WIDTH)
                line_buf[ipru_pkg::ADDR_W'(load_pos)] = pixel;
            load_pos++;
            if (load_pos >= w)
            begin
                load_pos = 0;
                in_emit = 1'b1;
            end
            res.status = ipru_pkg::ST_LOADED;
            return res;
        end
        if (!in_emit)
            return res;
        pad = (4 - ((w * f * 3) & 3)) & 3;
        if (in_pad)
        begin
            pad_pos++;
            if (pad_pos >= pad)
            begin
                pad_pos = 0;
                in_pad = 1'b0;
                res.row_end = 1'b1;
                res.image_end = close_output_row();
            end
            res.status = ipru_pkg::ST_PAD;
            return res;
        end
        px = (col_pos < ipru_pkg::MAX_WIDTH) ? line_buf[ipru_pkg::ADDR_W'(col_pos)] : '0;
        px_rep++;
        if (px_rep >= f)
        begin
            px_rep = 0;
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                if (pad > 0)
                    in_pad = 1'b1;
                else
                begin
                    res.row_end = 1'b1;
                    res.image_end = close_output_row();
                end
            end
        end
        res.status = ipru_pkg::ST_PIXEL;
        res.blue   = px[7:0];
        res.green  = px[15:8];
        res.red    = px[23:16];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: offers one item, predicts on the accepting edge
    // ------------------------------------------------------------------------
    task automatic send_item(input logic func, input logic [23:0] pixel);
        int unsigned     gap;
        upscale_result_t res;
        gap = idle_on ? $urandom_range(7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= pixel;
        do
            @(posedge clk);
        while (!s_tready);
        // valid stays high; a gap in the next call or a register write lowers it
        res = predict_upscale(func, pixel);
        expected_results.push_back(res);
        last_row_end = res.row_end;
        if (res.status != ipru_pkg::ST_REJECTED)
            n_useful_sent++;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // register writes only with the pipeline empty
    task automatic write_reg(input ipru_pkg::cfg_idx_t idx,
                             input logic [ipru_pkg::CFG_DATA_W-1:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (PIPE_DEPTH + 1) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            ipru_pkg::CFG_SCALE_FACTOR:  factor_reg = value[ipru_pkg::FACTOR_W-1:0];
            ipru_pkg::CFG_SOURCE_WIDTH:  width_reg  = value[ipru_pkg::WIDTH_W-1:0];
            ipru_pkg::CFG_SOURCE_HEIGHT: height_reg = value[ipru_pkg::HEIGHT_W-1:0];
            default: ;
        endcase
        n_settings++;
    endtask

    task automatic set_geometry(input int unsigned f, input int unsigned w,
                                input int unsigned h);
        write_reg(ipru_pkg::CFG_SCALE_FACTOR, ipru_pkg::CFG_DATA_W'(f));
        write_reg(ipru_pkg::CFG_SOURCE_WIDTH, ipru_pkg::CFG_DATA_W'(w));
        write_reg(ipru_pkg::CFG_SOURCE_HEIGHT, ipru_pkg::CFG_DATA_W'(h));
    endtask

    task automatic load_row();
        while (!in_emit)
            send_item(FUNC_LOAD, 24'($urandom));
    endtask

    task automatic emit_row_set();
        while (in_emit)
            send_item(FUNC_EMIT, 24'($urandom));
    endtask

    // emit up to and including the next row end
    task automatic emit_one_row();
        do
            send_item(FUNC_EMIT, 24'($urandom));
        while (!last_row_end);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset geometry (1x1, factor 1): one pixel plus one pad byte per row;
    // wrong-phase items in both directions; pixel extremes
    task automatic test_phases_and_pixels();
        send_item(FUNC_EMIT, 24'hFFFFFF);     // rejected, load phase
        send_item(FUNC_LOAD, 24'hFFFFFF);
        send_item(FUNC_LOAD, 24'h000000);     // rejected, emit phase
        send_item(FUNC_EMIT, 24'h000000);
        send_item(FUNC_EMIT, 24'hFFFFFF);     // pad, row and image end
        send_item(FUNC_LOAD, 24'h000000);
        send_item(FUNC_EMIT, 24'hFFFFFF);
        send_item(FUNC_EMIT, 24'h000000);
        send_item(FUNC_LOAD, 24'h55AA55);
        send_item(FUNC_EMIT, 24'hAA55AA);
        send_item(FUNC_EMIT, 24'h55AA55);
        send_item(FUNC_LOAD, 24'hAA55AA);
        send_item(FUNC_EMIT, 24'h55AA55);
        send_item(FUNC_EMIT, 24'hAA55AA);
    endtask

    // widths 2..4 at factor 1 give 2, 3 and 0 pad bytes
    task automatic test_row_padding();
        for (int w = 2; w <= 4; w++)
        begin
            write_reg(ipru_pkg::CFG_SOURCE_WIDTH, ipru_pkg::CFG_DATA_W'(w));
            load_row();
            emit_row_set();
        end
    endtask

    // factor 0 acts as 1; 127 clamps to 100: one full output row of 100
    // copies, then the factor drops to 2 so the second row repeat closes
    task automatic test_factor_limits();
        set_geometry(0, 3, 1);
        load_row();
        emit_row_set();
        set_geometry(127, 1, 1);
        load_row();
        idle_on = 1'b0;
        emit_one_row();
        idle_on = 1'b1;
        write_reg(ipru_pkg::CFG_SCALE_FACTOR, ipru_pkg::CFG_DATA_W'(2));
        emit_row_set();
    endtask

    // width 0 acts as 1; 4095 keeps loading past small indexes, and a width
    // lowered below the load index ends the row on the next load
    task automatic test_width_limits();
        set_geometry(1, 0, 1);
        load_row();
        emit_row_set();
        write_reg(ipru_pkg::CFG_SOURCE_WIDTH, ipru_pkg::CFG_DATA_W'(4095));
        repeat (3)
            send_item(FUNC_LOAD, 24'($urandom));
        write_reg(ipru_pkg::CFG_SOURCE_WIDTH, ipru_pkg::CFG_DATA_W'(2));
        load_row();
        emit_row_set();
    endtask

    // height 0 acts as 1; wrap over several images; height lowered below the
    // row count mid-image ends the image on the next row
    task automatic test_height_wrap();
        set_geometry(2, 2, 0);
        load_row();
        emit_row_set();
        write_reg(ipru_pkg::CFG_SOURCE_HEIGHT, ipru_pkg::CFG_DATA_W'(3));
        repeat (6)
        begin
            load_row();
            emit_row_set();
        end
        set_geometry(1, 1, 65535);
        repeat (2)
        begin
            load_row();
            emit_row_set();
        end
        write_reg(ipru_pkg::CFG_SOURCE_HEIGHT, ipru_pkg::CFG_DATA_W'(1));
        load_row();
        emit_row_set();
        write_reg(ipru_pkg::CFG_SOURCE_HEIGHT, ipru_pkg::CFG_DATA_W'(2));
        load_row();
        emit_row_set();
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_output_backpressure();
        set_geometry(2, 4, 1);
        idle_on = 1'b0;
        holds_asked++;
        load_row();
        emit_row_set();
        idle_on = 1'b1;
    endtask

    task automatic pick_random_setting();
        int unsigned sel;
        sel = $urandom_range(7);
        if (sel == 0)
            write_reg(ipru_pkg::CFG_SCALE_FACTOR,
                      ipru_pkg::CFG_DATA_W'($urandom_range(4, 5)));
        else if (sel <= 4)
            write_reg(ipru_pkg::CFG_SCALE_FACTOR,
                      ipru_pkg::CFG_DATA_W'($urandom_range(3)));
        if ($urandom_range(1) == 0)
            write_reg(ipru_pkg::CFG_SOURCE_WIDTH,
                      ipru_pkg::CFG_DATA_W'($urandom_range(7)));
        if ($urandom_range(2) == 0)
            write_reg(ipru_pkg::CFG_SOURCE_HEIGHT,
                      ($urandom_range(9) == 0) ? ipru_pkg::CFG_DATA_W'(65535)
                                               : ipru_pkg::CFG_DATA_W'($urandom_range(3)));
    endtask

    // mostly well-formed rows with random content; some wrong-phase noise
    // and some register changes part way through loading a row
    task automatic test_random_stream(input int unsigned target);
        int unsigned start_count;
        start_count = n_useful_sent;
        while (n_useful_sent - start_count < target)
        begin
            idle_on = ($urandom_range(4) != 0);
            if ($urandom_range(2) == 0)
                pick_random_setting();
            if ($urandom_range(9) == 0)
                send_item(FUNC_EMIT, 24'($urandom));
            while (!in_emit)
            begin
                if ($urandom_range(24) == 0)
                    pick_random_setting();
                else if ($urandom_range(19) == 0)
                    send_item(FUNC_EMIT, 24'($urandom));
                else
                    send_item(FUNC_LOAD, 24'($urandom));
            end
            while (in_emit)
            begin
                if ($urandom_range(29) == 0)
                    send_item(FUNC_LOAD, 24'($urandom));
                else
                    send_item(FUNC_EMIT, 24'($urandom));
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= FUNC_LOAD;
        cfg_we    <= 1'b0;
        cfg_index <= ipru_pkg::CFG_SCALE_FACTOR;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_phases_and_pixels();
        test_row_padding();
        test_factor_limits();
        test_width_limits();
        test_height_wrap();
        test_output_backpressure();
        test_random_stream(280);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d register writes, %0d loads, %0d pixels out, %0d pad bytes,",
                 n_settings, n_loaded, n_pixels, n_pads);
        $display("%0d wrong-phase rejects and %0d complete images.", n_rejects, n_images);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall per transfer, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int unsigned stall;
        int unsigned holds_done;
        holds_done = 0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (holds_done != holds_asked)
            begin
                holds_done = holds_asked;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = idle_on ? $urandom_range(7) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each output transfer against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        upscale_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            case (m_tuser)
                ipru_pkg::ST_LOADED:   n_loaded++;
                ipru_pkg::ST_PIXEL:    n_pixels++;
                ipru_pkg::ST_PAD:      n_pads++;
                ipru_pkg::ST_REJECTED: n_rejects++;
                default: ;
            endcase
            if (m_tdata[24] === 1'b1)
                n_images++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected transfer: status %0d", m_tuser);
                n_errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    n_errors++;
                end
                if (m_tdata[7:0] !== want.blue)
                begin
                    $error("out_blue: expected %0h, got %0h", want.blue, m_tdata[7:0]);
                    n_errors++;
                end
                if (m_tdata[15:8] !== want.green)
                begin
                    $error("out_green: expected %0h, got %0h", want.green, m_tdata[15:8]);
                    n_errors++;
                end
                if (m_tdata[23:16] !== want.red)
                begin
                    $error("out_red: expected %0h, got %0h", want.red, m_tdata[23:16]);
                    n_errors++;
                end
                if (m_tlast !== want.row_end)
                begin
                    $error("row_end: expected %0b, got %0b", want.row_end, m_tlast);
                    n_errors++;
                end
                if (m_tdata[24] !== want.image_end)
                begin
                    $error("image_end: expected %0b, got %0b", want.image_end, m_tdata[24]);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer on either side ends the run
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

endmodule
